[src/ptpdi_pkg.sv]
// Shared types and constants for the PTP DeviceInfo field parser.
// Depends on nothing; the parser and the testbench import it, and the result interface uses its widths.
package ptpdi_pkg;

    localparam int TAG_W   = 4;
    localparam int VALUE_W = 32;
    localparam int REM_W   = 33;

    // Sizes in bytes of the fixed-length parts of the dataset.
    localparam logic [3:0] HEADER_BYTES = 4'd12;
    localparam logic [3:0] WIDE_BYTES   = 4'd4;
    localparam logic [3:0] NARROW_BYTES = 4'd2;

    // Field tags carried on the result channel.
    localparam logic [TAG_W-1:0] TAG_STD_VER   = 4'd0;
    localparam logic [TAG_W-1:0] TAG_VENDOR_ID = 4'd1;
    localparam logic [TAG_W-1:0] TAG_EXT_VER   = 4'd2;
    localparam logic [TAG_W-1:0] TAG_EXT_DESC  = 4'd3;
    localparam logic [TAG_W-1:0] TAG_FUNC_MODE = 4'd4;
    localparam logic [TAG_W-1:0] TAG_ARRAY0    = 4'd5;
    localparam logic [TAG_W-1:0] TAG_SERIAL    = 4'd13;

    typedef struct packed {
        logic [TAG_W-1:0]   field_tag;
        logic [VALUE_W-1:0] field_value;
        logic               last_of_field;
        logic               dataset_end;
    } result_t;

endpackage

[src/ptpdi_in_if.sv]
// Byte request channel of the PTP DeviceInfo field parser.
// Depends on nothing but the valid/ready handshake convention.
interface ptpdi_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_dataset;

    modport source (output valid, output data_byte, output start_of_dataset, input ready);
    modport sink   (input valid, input data_byte, input start_of_dataset, output ready);
endinterface

[src/ptpdi_out_if.sv]
// Field result channel of the PTP DeviceInfo field parser.
// Depends on ptpdi_pkg for the field widths.
interface ptpdi_out_if;
    logic                        valid;
    logic                        ready;
    logic [ptpdi_pkg::TAG_W-1:0]   field_tag;
    logic [ptpdi_pkg::VALUE_W-1:0] field_value;
    logic                        last_of_field;
    logic                        dataset_end;

    modport source (output valid, output field_tag, output field_value,
                    output last_of_field, output dataset_end, input ready);
    modport sink   (input valid, input field_tag, input field_value,
                    input last_of_field, input dataset_end, output ready);
endinterface

[src/ptp_device_info_field_parser.sv]
// PTP DeviceInfo dataset field parser, top level.
// Depends on ptpdi_pkg, ptpdi_in_if and ptpdi_out_if.
//
// Usage:
// The dataset channel carries one raw byte of a DeviceInfo dataset per request,
// with start_of_dataset set on the first byte of the container header. The
// fields channel carries tagged results: scalar fields, array codes and UTF-16
// string units, in dataset order, each with last_of_field and dataset_end.
// The result of a byte is registered in the output register, or in the skid
// entry if a held result is not taken. Throughput: one byte per cycle while
// the dataset channel is ready, set by the single stage-update pass from the
// byte to the parse state. A byte that completes no element gives no result.
// Results pass through an output register backed by one skid entry, so a
// byte is still accepted while a result waits; only when both entries hold
// results does the dataset channel drop ready until the receiver takes one.
// Reset clears the parse state to the header stage and empties both result
// entries; bytes after reset are parsed as if the first one carried the
// start flag. A start flag at any time drops the parse under way. Bytes after
// the end of the serial number string are accepted and ignored.
module ptp_device_info_field_parser (
    input  logic        clk,
    input  logic        rst_n,
    ptpdi_in_if.sink    dataset,
    ptpdi_out_if.source fields
);
    import ptpdi_pkg::*;

    typedef enum logic [4:0] {
        STG_HEADER   = 5'd0,
        STG_STDVER   = 5'd1,
        STG_VENDOR   = 5'd2,
        STG_EXTVER   = 5'd3,
        STG_DESC_LEN = 5'd4,
        STG_DESC     = 5'd5,
        STG_FMODE    = 5'd6,
        STG_ARR_LEN0 = 5'd7,
        STG_ARR_LAST = 5'd16,
        STG_STR_LEN0 = 5'd17,
        STG_SERIAL   = 5'd24,
        STG_DONE     = 5'd25
    } stage_t;

    // Parse state.
    logic [4:0]       stage_reg, stage_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [31:0]      asm_reg, asm_next;

    // Output register and skid entry.
    result_t out_reg, out_next, skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;

    logic    accept, take;
    logic    res_valid;
    result_t res;

    // Working copies of the state after a possible restart.
    logic [4:0]       s;
    logic [REM_W-1:0] rem, rem_ld, rem_dec;
    logic [31:0]      asm_cur, asm_shift, value;
    logic [3:0]       size;
    logic             is_arr_len, is_str_len;
    logic [4:0]       unit_off;
    logic [3:0]       unit_tag;

    assign dataset.ready = !skid_valid_reg;
    assign accept        = dataset.valid && dataset.ready;
    assign take          = out_valid_reg && fields.ready;

    always_comb
    begin
        s       = dataset.start_of_dataset ? STG_HEADER : stage_reg;
        rem     = dataset.start_of_dataset ? '0 : rem_reg;
        asm_cur = dataset.start_of_dataset ? '0 : asm_reg;

        asm_shift = {dataset.data_byte, asm_cur[31:8]};

        // Array count stages are the odd stages from the first count on; string
        // count stages are the description count and the odd stages from the first string count on.
        is_arr_len = (s >= STG_ARR_LEN0) && (s < STG_STR_LEN0) && s[0];
        is_str_len = (s == STG_DESC_LEN) ||
                     ((s >= STG_STR_LEN0) && (s < STG_DONE) && s[0]);

        if (s == STG_HEADER)
        begin
            size = HEADER_BYTES;
        end
        else if (s == STG_VENDOR || is_arr_len)
        begin
            size = WIDE_BYTES;
        end
        else if (s == STG_STDVER || s == STG_EXTVER || s == STG_FMODE)
        begin
            size = NARROW_BYTES;
        end
        else
        begin
            size = 4'd0;
        end

        rem_ld  = (rem == '0 || rem > REM_W'(size)) ? REM_W'(size) : rem;
        rem_dec = rem_ld - REM_W'(1);
        value   = (size == WIDE_BYTES) ? asm_shift : {16'd0, asm_shift[31:16]};

        unit_off = s - 5'd8;
        unit_tag = (s == STG_DESC) ? TAG_EXT_DESC : (TAG_ARRAY0 + 4'(unit_off[4:1]));

        stage_next = stage_reg;
        rem_next   = rem_reg;
        asm_next   = asm_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (accept)
        begin
            stage_next = s;
            rem_next   = rem;
            asm_next   = asm_cur;
            if (s >= STG_DONE)
            begin
                res_valid = 1'b0;
            end
            else if (size != 4'd0)
            begin
                asm_next = asm_shift;
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    if (s == STG_HEADER)
                    begin
                        stage_next = STG_STDVER;
                    end
                    else if (is_arr_len)
                    begin
                        if (value == '0)
                        begin
                            stage_next = s + 5'd2;
                        end
                        else
                        begin
                            rem_next   = {value, 1'b0};
                            stage_next = s + 5'd1;
                        end
                    end
                    else
                    begin
                        stage_next          = s + 5'd1;
                        res_valid           = 1'b1;
                        res.field_value     = value;
                        res.last_of_field   = 1'b1;
                        case (s)
                            STG_STDVER: res.field_tag = TAG_STD_VER;
                            STG_VENDOR: res.field_tag = TAG_VENDOR_ID;
                            STG_EXTVER: res.field_tag = TAG_EXT_VER;
                            default:    res.field_tag = TAG_FUNC_MODE;
                        endcase
                    end
                end
            end
            else if (is_str_len)
            begin
                if (dataset.data_byte == 8'd0)
                begin
                    stage_next = s + 5'd2;
                end
                else
                begin
                    rem_next   = {24'd0, dataset.data_byte, 1'b0};
                    stage_next = s + 5'd1;
                end
            end
            else if (rem == '0)
            begin
                // Element stage with nothing left to read.
                stage_next = s + 5'd1;
            end
            else
            begin
                asm_next = asm_shift;
                rem_next = rem - REM_W'(1);
                if (!rem_next[0])
                begin
                    res_valid         = 1'b1;
                    res.field_tag     = unit_tag;
                    res.field_value   = {16'd0, asm_shift[31:16]};
                    res.last_of_field = (rem_next == '0);
                    res.dataset_end   = (rem_next == '0) && (s == STG_SERIAL);
                    if (rem_next == '0)
                    begin
                        stage_next = s + 5'd1;
                    end
                end
            end
        end
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = res;
                skid_valid_next = res_valid;
            end
            else
            begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg      <= STG_HEADER;
            rem_reg        <= '0;
            asm_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            stage_reg      <= stage_next;
            rem_reg        <= rem_next;
            asm_reg        <= asm_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign fields.valid         = out_valid_reg;
    assign fields.field_tag     = out_reg.field_tag;
    assign fields.field_value   = out_reg.field_value;
    assign fields.last_of_field = out_reg.last_of_field;
    assign fields.dataset_end   = out_reg.dataset_end;

    // The skid entry is only ever filled behind a held output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register is empty");

    // The end of the dataset is only flagged on the last serial number unit.
    a_end_on_serial: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.dataset_end) |->
            (out_reg.field_tag == TAG_SERIAL && out_reg.last_of_field))
        else $error("dataset_end on a result that is not the last serial unit");

    // A start flag restarts the header count with one byte consumed.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && dataset.start_of_dataset) |=>
            (stage_reg == STG_HEADER && rem_reg == REM_W'(HEADER_BYTES - 4'd1)))
        else $error("start flag did not restart the header");

    // Once the dataset is done, bytes without a start flag give no result.
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg >= STG_DONE && !dataset.start_of_dataset) |-> !res_valid)
        else $error("result produced after the end of the dataset");

    // A result that was held stays in place until the receiver takes it.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !fields.ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("held result was lost or changed");

endmodule

[tb/ptp_device_info_field_parser_test.sv]
// Self-checking testbench for the PTP DeviceInfo field parser.
// Depends on ptpdi_pkg, ptpdi_in_if, ptpdi_out_if and ptp_device_info_field_parser.
// Feeds whole and broken DeviceInfo datasets byte by byte and checks every field result.
module ptp_device_info_field_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptpdi_pkg::*;

    // Parse stages of the dataset walk. Each array and each string has a
    // count stage followed by its element stage, so the stages come in pairs.
    localparam logic [4:0] STG_HEADER    = 5'd0;
    localparam logic [4:0] STG_STDVER    = 5'd1;
    localparam logic [4:0] STG_VENDOR    = 5'd2;
    localparam logic [4:0] STG_EXTVER    = 5'd3;
    localparam logic [4:0] STG_DESC_LEN  = 5'd4;
    localparam logic [4:0] STG_DESC      = 5'd5;
    localparam logic [4:0] STG_FMODE     = 5'd6;
    localparam logic [4:0] STG_ARR_LEN0  = 5'd7;
    localparam logic [4:0] STG_ARR_UNIT0 = 5'd8;
    localparam logic [4:0] STG_STR_LEN0  = 5'd17;
    localparam logic [4:0] STG_SERIAL    = 5'd24;
    localparam logic [4:0] STG_DONE      = 5'd25;

    localparam int ITEM_TARGET   = 650;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 20;
    localparam int IDLE_LIMIT    = 2000;
    localparam int REPORT_LIMIT  = 10;

    // Keeps its own copy of the parse state, turns every accepted byte into
    // the field result it should cause, and checks results in order.
    class field_scoreboard;
        logic [4:0]       stage;
        logic [REM_W-1:0] remaining;
        logic [31:0]      word;
        result_t          expected_fields[$];
        int               mismatches;
        int               fields_checked;
        int               dataset_ends;

        function new();
            restart();
            mismatches     = 0;
            fields_checked = 0;
            dataset_ends   = 0;
        endfunction

        function void restart();
            stage     = STG_HEADER;
            remaining = '0;
            word      = '0;
        endfunction

        function bit is_array_len(logic [4:0] s);
            return s >= STG_ARR_LEN0 && s < STG_STR_LEN0 && s[0];
        endfunction

        function bit is_string_len(logic [4:0] s);
            return s == STG_DESC_LEN || (s >= STG_STR_LEN0 && s < STG_DONE && s[0]);
        endfunction

        function void push_field(logic [3:0] tag, logic [31:0] value, logic last,
                                 logic ds_end);
            result_t r;
            r.field_tag     = tag;
            r.field_value   = value;
            r.last_of_field = last;
            r.dataset_end   = ds_end;
            expected_fields.push_back(r);
        endfunction

        function int pending();
            return expected_fields.size();
        endfunction

        // Advance the parse by one byte.
        function void parse_byte(logic [7:0] b, logic sof);
            logic [4:0]  s;
            logic [3:0]  size;
            logic [31:0] value;
            logic [3:0]  tag;
            if (sof)
                restart();
            s = stage;
            if (s >= STG_DONE)
                return;

            if (s == STG_HEADER)
                size = HEADER_BYTES;
            else if (s == STG_VENDOR || is_array_len(s))
                size = WIDE_BYTES;
            else if (s == STG_STDVER || s == STG_EXTVER || s == STG_FMODE)
                size = NARROW_BYTES;
            else
                size = '0;

            if (size != 0)
            begin
                // Fixed-size part: a zero count means the part is just starting.
                if (remaining == 0 || remaining > size)
                    remaining = REM_W'(size);
                word = {b, word[31:8]};
                remaining = remaining - 1'b1;
                if (remaining != 0)
                    return;
                if (s == STG_HEADER)
                begin
                    stage = STG_STDVER;
                    return;
                end
                value = (size == WIDE_BYTES) ? word : {16'h0, word[31:16]};
                stage = s + 5'd1;
                if (is_array_len(s))
                begin
                    // An empty array skips its element stage altogether.
                    if (value == 0)
                        stage = s + 5'd2;
                    else
                        remaining = {value, 1'b0};
                end
                else if (s == STG_STDVER)
                    push_field(TAG_STD_VER, value, 1'b1, 1'b0);
                else if (s == STG_VENDOR)
                    push_field(TAG_VENDOR_ID, value, 1'b1, 1'b0);
                else if (s == STG_EXTVER)
                    push_field(TAG_EXT_VER, value, 1'b1, 1'b0);
                else
                    push_field(TAG_FUNC_MODE, value, 1'b1, 1'b0);
                return;
            end

            if (is_string_len(s))
            begin
                if (b == 0)
                    stage = s + 5'd2;
                else
                begin
                    remaining = REM_W'({b, 1'b0});
                    stage = s + 5'd1;
                end
                return;
            end

            // Element stage of an array or a string: two bytes per unit.
            if (remaining == 0)
            begin
                stage = s + 5'd1;
                return;
            end
            word = {b, word[31:8]};
            remaining = remaining - 1'b1;
            if (remaining[0])
                return;
            if (remaining == 0)
                stage = s + 5'd1;
            tag = (s == STG_DESC) ? TAG_EXT_DESC : TAG_ARRAY0 + 4'((s - STG_ARR_UNIT0) >> 1);
            push_field(tag, {16'h0, word[31:16]}, remaining == 0,
                       remaining == 0 && s == STG_SERIAL);
        endfunction

        function void check_field(result_t got);
            result_t want;
            if (expected_fields.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected field tag %0d value %h last %b end %b", $realtime,
                             got.field_tag, got.field_value, got.last_of_field,
                             got.dataset_end);
                return;
            end
            want = expected_fields.pop_front();
            fields_checked++;
            if (got.dataset_end === 1'b1)
                dataset_ends++;
            if (got.field_tag !== want.field_tag || got.field_value !== want.field_value ||
                got.last_of_field !== want.last_of_field ||
                got.dataset_end !== want.dataset_end)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $write("%0t: field mismatch, expected tag %0d value %h last %b end %b,",
                           $realtime, want.field_tag, want.field_value,
                           want.last_of_field, want.dataset_end);
                    $display(" got tag %0d value %h last %b end %b", got.field_tag,
                             got.field_value, got.last_of_field, got.dataset_end);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ptpdi_in_if  dataset_ch ();
    ptpdi_out_if fields_ch ();

    ptp_device_info_field_parser u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .dataset (dataset_ch),
        .fields  (fields_ch)
    );

    field_scoreboard field_board = new();

    logic [7:0] dataset_bytes[$];
    int         bytes_sent     = 0;
    int         bytes_ignored  = 0;
    int         input_stalls   = 0;
    int         holds_done     = 0;
    int         idle_cycles    = 0;
    bit         sender_calm    = 1'b0;
    bit         receiver_calm  = 1'b0;
    bit         hold_request   = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle stretch length: mostly none or short, now and then a long one.
    function automatic int pick_idle(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Field contents: style 0 gives all zeros, style 1 all ones, style 2 a
    // random mix that still hits both extremes often.
    function automatic logic [31:0] pick_value(int style);
        if (style == 0)
            return '0;
        if (style == 1)
            return '1;
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_count(int fixed_n, int cap);
        if (fixed_n >= 0)
            return fixed_n;
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, cap);
        return $urandom_range(0, 3);
    endfunction

    function automatic void put_le(logic [31:0] value, int n);
        for (int i = 0; i < n; i++)
            dataset_bytes.push_back(value[8*i +: 8]);
    endfunction

    function automatic void put_string(int style, int fixed_n);
        int n;
        n = pick_count(fixed_n, 12);
        dataset_bytes.push_back(8'(n));
        repeat (n)
            put_le(pick_value(style), NARROW_BYTES);
    endfunction

    // Lays out one complete DeviceInfo dataset in dataset_bytes. A fixed_n of
    // zero or more gives every array and string that many elements.
    function automatic void build_dataset(int style, int fixed_n);
        int n;
        dataset_bytes.delete();
        repeat (HEADER_BYTES)
            dataset_bytes.push_back(8'($urandom));
        put_le(pick_value(style), NARROW_BYTES);
        put_le(pick_value(style), WIDE_BYTES);
        put_le(pick_value(style), NARROW_BYTES);
        put_string(style, fixed_n);
        put_le(pick_value(style), NARROW_BYTES);
        repeat (5)
        begin
            n = pick_count(fixed_n, 8);
            put_le(n, WIDE_BYTES);
            repeat (n)
                put_le(pick_value(style), NARROW_BYTES);
        end
        repeat (4)
            put_string(style, fixed_n);
    endfunction

    // Offers one request and returns at the falling edge after it is taken.
    task automatic send_byte(logic [7:0] b, logic sof);
        int gap;
        gap = pick_idle(sender_calm);
        if (gap > 0)
        begin
            dataset_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        dataset_ch.valid            <= 1'b1;
        dataset_ch.data_byte        <= b;
        dataset_ch.start_of_dataset <= sof;
        do
            @(posedge clk);
        while (dataset_ch.ready !== 1'b1);
        field_board.parse_byte(b, sof);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_prefix(int count, bit flagged);
        for (int i = 0; i < count; i++)
            send_byte(dataset_bytes[i], flagged && i == 0);
    endtask

    // Bytes past the end of a dataset: the parser must swallow them silently.
    task automatic send_trailing(int n);
        repeat (n)
        begin
            send_byte(8'($urandom), 1'b0);
            bytes_ignored++;
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request so that
    // the output entries fill and the parser has to drop its input ready.
    initial
    begin
        int stall_left;
        stall_left = 0;
        fields_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                fields_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                holds_done++;
            end
            else if (stall_left > 0)
            begin
                fields_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                fields_ch.ready <= 1'b1;
                stall_left = pick_idle(receiver_calm);
            end
        end
    end

    // Results are sampled at the rising edge, before the block updates them.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n === 1'b1 && fields_ch.valid === 1'b1 && fields_ch.ready === 1'b1)
        begin
            got.field_tag     = fields_ch.field_tag;
            got.field_value   = fields_ch.field_value;
            got.last_of_field = fields_ch.last_of_field;
            got.dataset_end   = fields_ch.dataset_end;
            field_board.check_field(got);
        end
    end

    // Watchdog: any stretch without a handshake on either side that runs
    // far past the longest legal stall means the block has hung.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (dataset_ch.valid === 1'b1 && dataset_ch.ready !== 1'b1)
                input_stalls++;
            if ((dataset_ch.valid === 1'b1 && dataset_ch.ready === 1'b1) ||
                (fields_ch.valid === 1'b1 && fields_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no request or result moved for %0d cycles", $realtime,
                         IDLE_LIMIT);
                $display("ptp_device_info_field_parser regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int kind;
        int cut;
        int round;
        round = 0;
        rst_n = 1'b0;
        dataset_ch.valid = 1'b0;
        dataset_ch.data_byte = '0;
        dataset_ch.start_of_dataset = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. The first dataset comes straight after reset with no
        // start flag, all scalars zero and every array and string empty, so the
        // serial string is empty too and nothing carries the end marker.
        build_dataset(0, 0);
        send_prefix(dataset_bytes.size(), 1'b0);
        send_trailing(2);

        // All-ones contents with one element everywhere; the single serial
        // unit closes the dataset.
        build_dataset(1, 1);
        send_prefix(dataset_bytes.size(), 1'b1);
        send_trailing(3);

        // Largest possible operations count, cut short by the next start flag.
        build_dataset(2, 0);
        send_prefix(23, 1'b1);
        repeat (4)
            send_byte(8'hFF, 1'b0);
        repeat (6)
            send_byte(8'($urandom), 1'b0);

        // Longest description string, cut off in the middle of a unit.
        build_dataset(2, 0);
        send_prefix(20, 1'b1);
        send_byte(8'hFF, 1'b0);
        repeat (9)
            send_byte(8'($urandom), 1'b0);

        // Random part: mostly well-formed datasets with random contents, some
        // truncated by a restart, some plain noise with stray start flags.
        while (bytes_sent - bytes_ignored < ITEM_TARGET)
        begin
            round++;
            sender_calm   = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
            if (round == 3)
            begin
                sender_calm  = 1'b1;
                hold_request = 1'b1;
            end
            if (round == 2)
            begin
                // Let the parser drain completely before going on.
                dataset_ch.valid <= 1'b0;
                while (field_board.pending() != 0)
                    @(posedge clk);
                repeat ($urandom_range(5, 20)) @(negedge clk);
            end
            kind = $urandom_range(0, 9);
            // The hold-off round always carries a full dataset so results pile up.
            if (round == 3)
                kind = 2;
            if (kind == 0)
            begin
                repeat ($urandom_range(4, 24))
                    send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end
            else
            begin
                build_dataset(2, -1);
                cut = (kind == 1) ? $urandom_range(1, dataset_bytes.size() - 1)
                                  : dataset_bytes.size();
                send_prefix(cut, 1'b1);
                if (kind != 1)
                    send_trailing($urandom_range(0, 3));
            end
        end
        dataset_ch.valid <= 1'b0;

        while (field_board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d dataset bytes (%0d past a dataset end), checked %0d field results,",
                 bytes_sent, bytes_ignored, field_board.fields_checked);
        $display("saw %0d dataset end markers and %0d input stall cycles over %0d hold-off(s).",
                 field_board.dataset_ends, input_stalls, holds_done);
        if (field_board.mismatches == 0 && field_board.pending() == 0)
            $display("ptp_device_info_field_parser regression: pass");
        else
            $display("ptp_device_info_field_parser regression: fail");
        $finish;
    end

endmodule
